// ===== sv/word_frequency_table_unit_assert.svh =====
// Assertion macros for the word frequency table unit.
`ifndef WORD_FREQUENCY_TABLE_UNIT_ASSERT_SVH
`define WORD_FREQUENCY_TABLE_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define WFT_ASSERT(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("wft assertion failed");
`define WFT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wft assertion failed");
`else
`define WFT_ASSERT(lbl, clk, rst, expr)
`define WFT_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== sv/wft_pkg.sv =====
// ---------------------------------------------------------------------------
// wft_pkg
// Shared types and constants of the word frequency table unit.
// ---------------------------------------------------------------------------
`default_nettype none
package wft_pkg;
  localparam int TABLE_DEPTH_DEF = 128;
  localparam int MAX_CHARS_DEF   = 16;
  localparam int COUNT_BITS_DEF  = 16;

  localparam logic [7:0] ENTRY_LIMIT_RST = 8'd128;
  localparam logic       REG_ENTRY_LIMIT = 1'b0;

  localparam logic [7:0] CHAR_UPPER_A = 8'd65;
  localparam logic [7:0] CHAR_UPPER_Z = 8'd90;
  localparam logic [7:0] CHAR_LOWER_A = 8'd97;
  localparam logic [7:0] CHAR_LOWER_Z = 8'd122;

  typedef struct packed {
    logic [6:0]  slot;
    logic [15:0] word_count;
    logic        new_word;
    logic        table_full;
    logic        truncated;
  } res_t;
endpackage
`default_nettype wire

// ===== sv/wft_fifo.sv =====
// ---------------------------------------------------------------------------
// wft_fifo
// Short register queue carrying finished words from front to back.
// ---------------------------------------------------------------------------
`default_nettype none
module wft_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  q_full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  q_empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    occ;

  assign q_full  = (occ == CW'(DEPTH));
  assign q_empty = (occ == '0);
  assign rd_data = slots[rd_ptr];

  // store beat
  always_ff @(posedge clk) begin
    if (wr_en && !q_full) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      occ    <= '0;
    end else begin
      if (wr_en && !q_full) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (rd_en && !q_empty) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if ((wr_en && !q_full) && !(rd_en && !q_empty)) begin
        occ <= occ + CW'(1);
      end else if (!(wr_en && !q_full) && (rd_en && !q_empty)) begin
        occ <= occ - CW'(1);
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/wft_front.sv =====
// ---------------------------------------------------------------------------
// wft_front
// Classifies input bytes, assembles the pending word, hands finished words on.
// ---------------------------------------------------------------------------
`default_nettype none
module wft_front import wft_pkg::*; #(
  parameter int MAX_CHARS = MAX_CHARS_DEF,
  parameter int LW = $clog2(MAX_CHARS + 1),
  parameter int QW = 1 + LW + MAX_CHARS * 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire logic [7:0]    char_code,
  input  wire logic          end_of_input,
  input  wire logic          q_full,
  output logic               q_push,
  output logic [QW-1:0]      q_data
);
  localparam int CIW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;

  logic [7:0]    word_chars [MAX_CHARS];
  logic [LW-1:0] word_length;
  logic          word_overflow;
  logic          accept;
  logic          is_letter;
  logic [MAX_CHARS*8-1:0] packed_chars;

  assign accept    = push && !q_full;
  assign is_letter = !end_of_input &&
                     ((char_code >= CHAR_UPPER_A && char_code <= CHAR_UPPER_Z) ||
                      (char_code >= CHAR_LOWER_A && char_code <= CHAR_LOWER_Z));

  // zero letters past the length so stored rows compare as whole vectors
  always_comb begin
    for (int i = 0; i < MAX_CHARS; i++) begin
      packed_chars[i*8 +: 8] = (LW'(i) < word_length) ? word_chars[i] : 8'd0;
    end
  end

  assign q_push = accept && !is_letter && (word_length != '0);
  assign q_data = {word_overflow, word_length, packed_chars};

  // append letter
  always_ff @(posedge clk) begin
    if (accept && is_letter && (word_length < LW'(MAX_CHARS))) begin
      word_chars[word_length[CIW-1:0]] <= char_code;
    end
  end

  // track length and overflow, clear on word end
  always_ff @(posedge clk) begin
    if (rst) begin
      word_length   <= '0;
      word_overflow <= 1'b0;
    end else if (accept) begin
      if (is_letter) begin
        if (word_length < LW'(MAX_CHARS)) begin
          word_length <= word_length + LW'(1);
        end else begin
          word_overflow <= 1'b1;
        end
      end else begin
        word_length   <= '0;
        word_overflow <= 1'b0;
      end
    end
  end
endmodule
`default_nettype wire

// ===== sv/wft_back.sv =====
// ---------------------------------------------------------------------------
// wft_back
// Searches the word table one row at a time, updates counts, fills entries.
// ---------------------------------------------------------------------------
`default_nettype none
module wft_back import wft_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int MAX_CHARS   = MAX_CHARS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int LW = $clog2(MAX_CHARS + 1),
  parameter int QW = 1 + LW + MAX_CHARS * 8
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [7:0]    entry_limit,
  input  wire logic          q_empty,
  input  wire logic [QW-1:0] q_data,
  output logic               q_pop,
  input  wire logic          pop,
  output logic               empty,
  output res_t               res
);
  `include "word_frequency_table_unit_assert.svh"

  localparam int IW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int UW  = $clog2(TABLE_DEPTH + 1);
  localparam int LMW = (UW > 8) ? UW : 8;
  localparam int CHW = MAX_CHARS * 8;
  localparam int RW  = CHW + LW + COUNT_BITS;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_CMP  = 2'd2;
  localparam logic [1:0] S_MISS = 2'd3;

  logic [RW-1:0]         rows [TABLE_DEPTH];
  logic [RW-1:0]         rd_row;
  logic                  row_we;
  logic [IW-1:0]         row_wa;
  logic [RW-1:0]         row_wd;

  logic [1:0]            state;
  logic [UW-1:0]         idx;
  logic [UW-1:0]         used;
  logic                  out_valid;
  logic [CHW-1:0]        w_chars;
  logic [LW-1:0]         w_len;
  logic                  w_ovf;

  logic [CHW-1:0]        rd_chars;
  logic [LW-1:0]         rd_len;
  logic [COUNT_BITS-1:0] rd_cnt;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  hit;
  logic                  last;
  logic [LMW-1:0]        lim_ext;
  logic [LMW-1:0]        eff_limit;
  logic                  room;
  logic [31:0]           idx_w;
  logic [31:0]           used_w;
  logic [31:0]           cnt_w;

  assign {rd_chars, rd_len, rd_cnt} = rd_row;
  assign hit     = (rd_len == w_len) && (rd_chars == w_chars);
  assign last    = ((idx + UW'(1)) == used);
  assign cnt_inc = (&rd_cnt) ? rd_cnt : rd_cnt + COUNT_BITS'(1);
  assign lim_ext = LMW'(entry_limit);
  assign eff_limit = (lim_ext > LMW'(TABLE_DEPTH)) ? LMW'(TABLE_DEPTH) : lim_ext;
  assign room    = LMW'(used) < eff_limit;
  assign idx_w   = 32'(idx);
  assign used_w  = 32'(used);
  assign cnt_w   = 32'(cnt_inc);

  assign q_pop = (state == S_IDLE) && !q_empty && !out_valid;
  assign empty = !out_valid;

  // table row write port and registered read port
  always_comb begin
    row_we = 1'b0;
    row_wa = idx[IW-1:0];
    row_wd = {w_chars, w_len, cnt_inc};
    if (state == S_CMP && hit) begin
      row_we = 1'b1;
    end else if (state == S_MISS && room) begin
      row_we = 1'b1;
      row_wa = used[IW-1:0];
      row_wd = {w_chars, w_len, COUNT_BITS'(1)};
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      rows[row_wa] <= row_wd;
    end
    rd_row <= rows[idx[IW-1:0]];
  end

  // latch the word taken from the queue
  always_ff @(posedge clk) begin
    if (q_pop) begin
      {w_ovf, w_len, w_chars} <= q_data;
    end
  end

  // search sequencer, fill count and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && pop) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            idx   <= '0;
            state <= (used == '0) ? S_MISS : S_READ;
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (hit) begin
            out_valid      <= 1'b1;
            res.slot       <= idx_w[6:0];
            res.word_count <= cnt_w[15:0];
            res.new_word   <= 1'b0;
            res.table_full <= 1'b0;
            res.truncated  <= w_ovf;
            state          <= S_IDLE;
          end else if (last) begin
            state <= S_MISS;
          end else begin
            idx   <= idx + UW'(1);
            state <= S_READ;
          end
        end
        S_MISS: begin
          out_valid     <= 1'b1;
          res.truncated <= w_ovf;
          if (room) begin
            used           <= used + UW'(1);
            res.slot       <= used_w[6:0];
            res.word_count <= 16'd1;
            res.new_word   <= 1'b1;
            res.table_full <= 1'b0;
          end else begin
            res.slot       <= '0;
            res.word_count <= '0;
            res.new_word   <= 1'b0;
            res.table_full <= 1'b1;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `WFT_ASSERT(a_used_bounded, clk, rst, used <= UW'(TABLE_DEPTH))
  `WFT_ASSERT(a_flags_exclusive, clk, rst, !(out_valid && res.new_word && res.table_full))
  `WFT_ASSERT(a_pop_needs_free_out, clk, rst, !(q_pop && out_valid))
  `WFT_ASSERT_NEXT(a_miss_full, clk, rst, state == S_MISS && !room,
                   out_valid && res.table_full)
endmodule
`default_nettype wire

// ===== sv/word_frequency_table_unit.sv =====
// Word frequency table: letters are taken one per cycle into the pending word while
// the word queue is not full. Each stored row compared (up to the filled entries)
// takes a read and a compare state, plus a miss state when the word is new or refused.
// Table search reads rows via a registered read port beside one write port; finished
// words wait in a 4-deep queue so letter intake continues meanwhile.
// Synchronous active-high reset clears control state; table contents need no clear.
// ---------------------------------------------------------------------------
// word_frequency_table_unit
// Top level: configuration register, front classifier, word queue, table back.
// ---------------------------------------------------------------------------
`default_nettype none
module word_frequency_table_unit import wft_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int MAX_CHARS   = MAX_CHARS_DEF,
  parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  char_code,
  input  wire logic        end_of_input,
  output logic             empty,
  input  wire logic        pop,
  output logic [6:0]       slot,
  output logic [15:0]      word_count,
  output logic             new_word,
  output logic             table_full,
  output logic             truncated
);
  localparam int LW = $clog2(MAX_CHARS + 1);
  localparam int QW = 1 + LW + MAX_CHARS * 8;

  logic [7:0]    entry_limit;
  logic          q_push;
  logic [QW-1:0] q_wdata;
  logic          q_full;
  logic          q_pop;
  logic [QW-1:0] q_rdata;
  logic          q_empty;
  res_t          res;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ENTRY_LIMIT) ? {24'd0, entry_limit} : 32'd0;

  // configuration register write
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_limit <= ENTRY_LIMIT_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ENTRY_LIMIT) begin
      entry_limit <= pwdata[7:0];
    end
  end

  assign full = q_full;

  wft_front #(
    .MAX_CHARS (MAX_CHARS),
    .LW        (LW),
    .QW        (QW)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .char_code    (char_code),
    .end_of_input (end_of_input),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  wft_fifo #(
    .WIDTH (QW),
    .DEPTH (4)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (q_push),
    .wr_data (q_wdata),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rdata),
    .q_empty (q_empty)
  );

  wft_back #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MAX_CHARS   (MAX_CHARS),
    .COUNT_BITS  (COUNT_BITS),
    .LW          (LW),
    .QW          (QW)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .entry_limit (entry_limit),
    .q_empty     (q_empty),
    .q_data      (q_rdata),
    .q_pop       (q_pop),
    .pop         (pop),
    .empty       (empty),
    .res         (res)
  );

  assign slot       = res.slot;
  assign word_count = res.word_count;
  assign new_word   = res.new_word;
  assign table_full = res.table_full;
  assign truncated  = res.truncated;
endmodule
`default_nettype wire
